// ===== sv/mpre_pkg.sv =====
// ----------------------------------------------------------------------------
// mpre_pkg
// Shared types and constants of the median-edge-detector residual encoder.
// ----------------------------------------------------------------------------
package mpre_pkg;

  // line store sizing
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int NUM_CH        = 3;

  // field widths
  localparam int PIX_W      = 8;
  localparam int RES_W      = 9;
  localparam int LINE_W_W   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // quantizer: steps = 256 div level, recip = ceil(2^16 / steps)
  localparam int STEP_W     = 9;
  localparam int RECIP_W    = 17;
  localparam int RECIP_FRAC = 16;
  localparam int PROD_W     = PIX_W + RECIP_W;
  localparam int SCALE_W    = PIX_W + STEP_W;

  localparam logic [RECIP_W-1:0] STEP_NUM    = RECIP_W'(256);
  localparam logic [RECIP_W-1:0] RECIP_NUM   = RECIP_W'(65535);
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(1);
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(65536);

  // register reset values
  localparam logic [LINE_W_W-1:0] LINE_WIDTH_RESET = LINE_W_W'(640);

  // stream packing
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RES_W - 3 * PIX_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH = 3'd0,
    CFG_THREE_CH   = 3'd1,
    CFG_LEVEL_CH0  = 3'd2,
    CFG_LEVEL_CH1  = 3'd3,
    CFG_LEVEL_CH2  = 3'd4
  } cfg_reg_t;

  // position of one sample in the frame
  typedef struct packed {
    logic [1:0] ch;
    logic       col_zero;
    logic       first_row;
  } pos_t;

  // one result beat
  typedef struct packed {
    logic [PIX_W-1:0] abs_noise;
    logic [PIX_W-1:0] abs_error;
    logic [PIX_W-1:0] reconstructed;
    logic [RES_W-1:0] residual;
  } result_t;

endpackage

// ===== sv/mpre_div.sv =====
// ----------------------------------------------------------------------------
// mpre_div
// Restoring divider, one quotient bit per cycle, for the quantizer constants.
// ----------------------------------------------------------------------------
module mpre_div
  import mpre_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [RECIP_W-1:0] num,
  input  logic [STEP_W-1:0]  den,
  output logic               done,
  output logic [RECIP_W-1:0] quot
);

  localparam int CNT_W = $clog2(RECIP_W + 1);

  logic [RECIP_W-1:0] num_r;
  logic [STEP_W-1:0]  den_r;
  logic [STEP_W-1:0]  rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [STEP_W:0]    rem_sh;
  logic               ge;

  // one trial subtraction
  assign rem_sh = {rem_r, num_r[RECIP_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RECIP_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath, quotient shifts into the numerator register
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[RECIP_W-2:0], ge};
      rem_r <= ge ? STEP_W'(rem_sh - {1'b0, den_r}) : STEP_W'(rem_sh);
    end
  end

  assign done = done_r;
  assign quot = num_r;

endmodule

// ===== sv/mpre_pos.sv =====
// ----------------------------------------------------------------------------
// mpre_pos
// Raster position tracker: channel, column, first-row flag, line store address.
// ----------------------------------------------------------------------------
module mpre_pos
  import mpre_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic                           sof,
  input  logic                           three_ch,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_width,
  output pos_t                           pos,
  output logic [$clog2(3*MAX_WIDTH)-1:0] addr
);

  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int AW   = $clog2(3 * MAX_WIDTH);

  logic [1:0]      ch_r, ch_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic            fr_r, fr_nxt;

  logic [1:0]      nch;
  logic [1:0]      ch_b, ch_i, ch_p1;
  logic [COLW-1:0] col_b, col_i;
  logic            fr_b, fr_i;
  logic [CW-1:0]   col_p1;

  assign nch = three_ch ? 2'd3 : 2'd1;

  // position of the sample being accepted, with frame restart and wrap
  always_comb begin
    ch_b  = sof ? 2'd0 : ch_r;
    col_b = sof ? '0 : col_r;
    fr_b  = sof ? 1'b1 : fr_r;
    ch_i  = (ch_b >= nch) ? 2'd0 : ch_b;
    if (CW'(col_b) >= eff_width) begin
      col_i = '0;
      fr_i  = 1'b0;
    end else begin
      col_i = col_b;
      fr_i  = fr_b;
    end
  end

  // advance to the following sample
  always_comb begin
    ch_p1  = ch_i + 2'd1;
    col_p1 = CW'(col_i) + CW'(1);
    ch_nxt  = ch_p1;
    col_nxt = col_i;
    fr_nxt  = fr_i;
    if (ch_p1 >= nch) begin
      ch_nxt = 2'd0;
      if (col_p1 >= eff_width) begin
        col_nxt = '0;
        fr_nxt  = 1'b0;
      end else begin
        col_nxt = COLW'(col_p1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= 2'd0;
      col_r <= '0;
      fr_r  <= 1'b1;
    end else if (accept) begin
      ch_r  <= ch_nxt;
      col_r <= col_nxt;
      fr_r  <= fr_nxt;
    end
  end

  // entry index column * 3 + channel
  assign addr = (AW'(col_i) << 1) + AW'(col_i) + AW'(ch_i);

  assign pos.ch        = ch_i;
  assign pos.col_zero  = (col_i == '0);
  assign pos.first_row = fr_i;

endmodule

// ===== sv/mpre_line_mem.sv =====
// ----------------------------------------------------------------------------
// mpre_line_mem
// Line store of reconstructed samples, one write and one registered read port,
// with forwarding when a read meets a write to the same entry.
// ----------------------------------------------------------------------------
module mpre_line_mem
  import mpre_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(3*MAX_WIDTH)-1:0] rd_addr,
  output logic [PIX_W-1:0]               rd_data,
  input  logic                           wr_en,
  input  logic [$clog2(3*MAX_WIDTH)-1:0] wr_addr,
  input  logic [PIX_W-1:0]               wr_data
);

  localparam int DEPTH = 3 * MAX_WIDTH;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rd_q_r;
  logic [PIX_W-1:0] fwd_data_r;
  logic             fwd_sel_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data from the array, new data through the bypass
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_sel_r  <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_sel_r ? fwd_data_r : rd_q_r;

endmodule

// ===== sv/mpre_dp.sv =====
// ----------------------------------------------------------------------------
// mpre_dp
// Prediction and quantizer datapath with per-channel neighbor registers.
// Stage one: median prediction, error, magnitude times reciprocal.
// Stage two: quotient times steps, residual, reconstruction, noise.
// ----------------------------------------------------------------------------
module mpre_dp
  import mpre_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld,
  input  logic               sof_clr,
  input  logic [PIX_W-1:0]   pix,
  input  pos_t               pos,
  input  logic [STEP_W-1:0]  steps,
  input  logic [RECIP_W-1:0] recip,
  input  logic               s1_en,
  input  logic [PIX_W-1:0]   upper,
  input  logic               fin,
  output result_t            res
);

  // sample held for the duration of its work
  logic [PIX_W-1:0]   pix_r;
  pos_t               pos_r;
  logic [STEP_W-1:0]  steps_r;
  logic [RECIP_W-1:0] recip_r;

  // neighbors per channel
  logic [PIX_W-1:0] left_r [NUM_CH];
  logic [PIX_W-1:0] ul_r [NUM_CH];

  // stage one
  logic [PIX_W-1:0]  left_sel, ul_sel;
  logic [PIX_W-1:0]  a, b, c, lo, hi, pred;
  logic signed [RES_W-1:0] err;
  logic              neg;
  logic [PIX_W-1:0]  mag;
  logic [PROD_W-1:0] prod;

  // stage two registers
  logic [PIX_W-1:0]  pred_r, mag_r, b_r;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;

  logic [PIX_W-1:0]   quo;
  logic [SCALE_W-1:0] scaled;
  logic [PIX_W-1:0]   rmag;
  logic [RES_W-1:0]   residual;
  logic [PIX_W-1:0]   recon;

  always_ff @(posedge clk) begin
    if (ld) begin
      pix_r   <= pix;
      pos_r   <= pos;
      steps_r <= steps;
      recip_r <= recip;
    end
  end

  // neighbor select for the current channel
  always_comb begin
    left_sel = left_r[0];
    ul_sel   = ul_r[0];
    for (int k = 1; k < NUM_CH; k++) begin
      if (pos_r.ch == 2'(k)) begin
        left_sel = left_r[k];
        ul_sel   = ul_r[k];
      end
    end
  end

  // median edge detector, outside neighbors read as zero
  always_comb begin
    a  = pos_r.col_zero ? '0 : left_sel;
    b  = pos_r.first_row ? '0 : upper;
    c  = (pos_r.col_zero || pos_r.first_row) ? '0 : ul_sel;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      pred = hi;
    end else if (c >= hi) begin
      pred = lo;
    end else begin
      pred = PIX_W'((PIX_W+1)'(a) + (PIX_W+1)'(b) - (PIX_W+1)'(c));
    end
  end

  // error and scaled magnitude; lossless levels give steps 1, so residual = error
  assign err  = $signed({1'b0, pix_r}) - $signed({1'b0, pred});
  assign neg  = err[RES_W-1];
  assign mag  = PIX_W'(neg ? -err : err);
  assign prod = PROD_W'(mag) * PROD_W'(recip_r);

  always_ff @(posedge clk) begin
    if (s1_en) begin
      pred_r <= pred;
      mag_r  <= mag;
      neg_r  <= neg;
      prod_r <= prod;
      b_r    <= b;
    end
  end

  // truncated quotient back to a multiple of steps
  assign quo      = prod_r[RECIP_FRAC +: PIX_W];
  assign scaled   = SCALE_W'(quo) * SCALE_W'(steps_r);
  assign rmag     = scaled[PIX_W-1:0];
  assign residual = neg_r ? RES_W'(-{1'b0, rmag}) : {1'b0, rmag};
  assign recon    = pred_r + residual[PIX_W-1:0];

  // neighbor update at finish, frame restart wins over it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CH; k++) begin
        left_r[k] <= '0;
        ul_r[k]   <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_CH; k++) begin
        if (sof_clr) begin
          left_r[k] <= '0;
          ul_r[k]   <= '0;
        end else if (fin && (pos_r.ch == 2'(k))) begin
          left_r[k] <= recon;
          ul_r[k]   <= b_r;
        end
      end
    end
  end

  assign res.residual      = residual;
  assign res.reconstructed = recon;
  assign res.abs_error     = mag_r;
  assign res.abs_noise     = mag_r - rmag;

endmodule

// ===== sv/med_predictive_residual_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// med_predictive_residual_encoder_unit
// Median-edge-detector predictive encoder with quantized residuals and a
// line store of reconstructed samples.
//
//   channel  dir  tdata / data                          tuser / index
//   in_      in   [7:0] pixel_value                     [0] start_of_frame
//   out_     out  [8:0] residual, [16:9] reconstructed, -
//                 [24:17] abs_error, [32:25] abs_noise
//   cfg_     in   [11:0] register value                 [2:0] register index
//
// A sample is accepted with the line store read, then takes prediction and
// the first multiply; the finish cycle writes back and can accept the
// next sample. The line store read latency and the left-neighbor feedback
// set the sample pace. A quantization level write runs two divisions,
// steps then reciprocal, with in_tready and cfg_ready low. Reset is synchronous;
// the line store needs no clearing since the first row ignores what it reads.
// A stalled result holds in the output register while the next sample works.
// ----------------------------------------------------------------------------
module med_predictive_residual_encoder_unit
  import mpre_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // sample stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] pixel_value
  input  logic                   in_tuser,   // [0] start_of_frame
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // residual, reconstructed, abs_error, abs_noise
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(3 * MAX_WIDTH);
  localparam int WW = (CW > LINE_W_W) ? CW : LINE_W_W;

  typedef enum logic [1:0] {S_IDLE, S_PRED, S_FIN} state_t;
  typedef enum logic [1:0] {C_IDLE, C_STEPS, C_RECIP} cstate_t;

  state_t  state_r;
  cstate_t cstate_r;

  // configuration
  logic [LINE_W_W-1:0] line_width_r;
  logic                three_ch_r;
  logic [STEP_W-1:0]   steps_r [NUM_CH];
  logic [RECIP_W-1:0]  recip_r [NUM_CH];
  logic [1:0]          calc_ch_r;

  logic                cfg_acc, lvl_wr;
  logic [PIX_W-1:0]    lvl;
  logic                div_start, div_done;
  logic [RECIP_W-1:0]  div_num, div_quot;
  logic [STEP_W-1:0]   div_den;

  // stream control
  logic           accept, can_fin, fin;
  logic [WW-1:0]  lw_ext, max_ext, w_sat;
  logic [CW-1:0]  eff_width;
  pos_t           pos;
  logic [AW-1:0]  rd_addr, addr_r;
  logic [PIX_W-1:0] upper;
  logic [STEP_W-1:0]  steps_sel;
  logic [RECIP_W-1:0] recip_sel;
  result_t        res, out_res_r;
  logic           out_valid_r;

  // effective width, zero reads as one, clipped to the line store
  assign lw_ext    = WW'(line_width_r);
  assign max_ext   = WW'(MAX_WIDTH);
  assign w_sat     = (lw_ext == '0) ? WW'(1) : ((lw_ext > max_ext) ? max_ext : lw_ext);
  assign eff_width = CW'(w_sat);

  // handshakes
  assign can_fin   = !out_valid_r || out_tready;
  assign fin       = (state_r == S_FIN) && can_fin;
  assign in_tready = (cstate_r == C_IDLE) &&
                     ((state_r == S_IDLE) || ((state_r == S_FIN) && can_fin));
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = (cstate_r == C_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;

  // sample position and line store address
  mpre_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .sof       (in_tuser),
    .three_ch  (three_ch_r),
    .eff_width (eff_width),
    .pos       (pos),
    .addr      (rd_addr)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= rd_addr;
    end
  end

  mpre_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (upper),
    .wr_en   (fin),
    .wr_addr (addr_r),
    .wr_data (res.reconstructed)
  );

  // quantizer constants of the sample's channel
  always_comb begin
    steps_sel = steps_r[0];
    recip_sel = recip_r[0];
    for (int k = 1; k < NUM_CH; k++) begin
      if (pos.ch == 2'(k)) begin
        steps_sel = steps_r[k];
        recip_sel = recip_r[k];
      end
    end
  end

  mpre_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld      (accept),
    .sof_clr (accept && in_tuser),
    .pix     (in_tdata[PIX_W-1:0]),
    .pos     (pos),
    .steps   (steps_sel),
    .recip   (recip_sel),
    .s1_en   (state_r == S_PRED),
    .upper   (upper),
    .fin     (fin),
    .res     (res)
  );

  // sample sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (fin) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_PRED;
          end
        end
        S_PRED: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin) begin
            state_r <= accept ? S_PRED : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // level writes go through the divider: steps, then reciprocal
  assign lvl    = cfg_data[PIX_W-1:0];
  assign lvl_wr = cfg_acc && ((cfg_index == CFG_LEVEL_CH0) ||
                              (cfg_index == CFG_LEVEL_CH1) ||
                              (cfg_index == CFG_LEVEL_CH2));
  assign div_start = ((cstate_r == C_IDLE) && lvl_wr) ||
                     ((cstate_r == C_STEPS) && div_done);
  assign div_num   = (cstate_r == C_IDLE) ? STEP_NUM : RECIP_NUM;
  assign div_den   = (cstate_r == C_IDLE) ?
                     ((lvl == '0) ? STEP_W'(1) : STEP_W'(lvl)) : div_quot[STEP_W-1:0];

  mpre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // register file and constant sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cstate_r     <= C_IDLE;
      line_width_r <= LINE_WIDTH_RESET;
      three_ch_r   <= 1'b1;
      calc_ch_r    <= 2'd0;
      for (int k = 0; k < NUM_CH; k++) begin
        steps_r[k] <= STEP_RESET;
        recip_r[k] <= RECIP_RESET;
      end
    end else begin
      case (cstate_r)
        C_IDLE: begin
          if (cfg_acc) begin
            case (cfg_index)
              CFG_LINE_WIDTH: line_width_r <= cfg_data[LINE_W_W-1:0];
              CFG_THREE_CH:   three_ch_r   <= cfg_data[0];
              CFG_LEVEL_CH0: begin
                calc_ch_r <= 2'd0;
                cstate_r  <= C_STEPS;
              end
              CFG_LEVEL_CH1: begin
                calc_ch_r <= 2'd1;
                cstate_r  <= C_STEPS;
              end
              CFG_LEVEL_CH2: begin
                calc_ch_r <= 2'd2;
                cstate_r  <= C_STEPS;
              end
              default: begin
              end
            endcase
          end
        end
        C_STEPS: begin
          if (div_done) begin
            for (int k = 0; k < NUM_CH; k++) begin
              if (calc_ch_r == 2'(k)) begin
                steps_r[k] <= div_quot[STEP_W-1:0];
              end
            end
            cstate_r <= C_RECIP;
          end
        end
        C_RECIP: begin
          if (div_done) begin
            for (int k = 0; k < NUM_CH; k++) begin
              if (calc_ch_r == 2'(k)) begin
                recip_r[k] <= div_quot + RECIP_W'(1);
              end
            end
            cstate_r <= C_IDLE;
          end
        end
        default: begin
          cstate_r <= C_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_res_r.abs_noise, out_res_r.abs_error,
                       out_res_r.reconstructed, out_res_r.residual};

endmodule

// ===== sv/mpre_checker.sv =====
// ----------------------------------------------------------------------------
// mpre_checker
// Port-level checks of the residual encoder, bound to the top level.
// ----------------------------------------------------------------------------
module mpre_checker
  import mpre_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_IDX_W-1:0]   cfg_index
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // quantization noise never exceeds the prediction error
  a_noise_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32:25] <= out_tdata[24:17]))
    else $error("abs_noise above abs_error");

  // a level write starts the constant update and blocks both inputs
  a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
    (cfg_index == CFG_LEVEL_CH0 || cfg_index == CFG_LEVEL_CH1 ||
     cfg_index == CFG_LEVEL_CH2)
    |=> !in_tready && !cfg_ready)
    else $error("level write did not block the sample stream");

  // samples are only taken while no constant update runs
  a_ready_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> cfg_ready)
    else $error("sample accepted during constant update");

endmodule

bind med_predictive_residual_encoder_unit mpre_checker u_mpre_checker (.*);
